// File: rtl/nksil_pkg.sv
// ----------------------------------------------------------------------------
// nksil_pkg
// Shared types and constants of the nearest-k sorted insertion list.
// ----------------------------------------------------------------------------
package nksil_pkg;

   localparam int DIST_W   = 32;
   localparam int ID_W     = 16;
   localparam int RANK_W   = 3;
   localparam int CSR_W    = 4;
   localparam logic [CSR_W-1:0] MAX_LIGHTS_RESET = 4'd8;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_READ
   } state_type;

   // control handed to every cell of the row
   typedef struct packed {
      logic enable;     // request accepted this cycle
      logic occupied;   // cell holds a live entry
      logic prev_le;    // upstream neighbor keeps its entry
   } cell_ctl_type;

   // status returned by every cell
   typedef struct packed {
      logic le;         // cell is occupied and stored distance <= offered distance
      logic take_new;   // this cell is the insertion point
   } cell_stat_type;

endpackage

// File: rtl/nksil_cell.sv
// ----------------------------------------------------------------------------
// nksil_cell
// One slot of the sorted row: compares, then keeps, loads the new entry or
// takes its upstream neighbor's entry.
// ----------------------------------------------------------------------------
module nksil_cell #(
   parameter int HANDLE_BITS = 16
) (
   input  logic                        clock,
   input  nksil_pkg::cell_ctl_type     ctl,
   input  logic [HANDLE_BITS-1:0]      new_handle,
   input  logic [nksil_pkg::DIST_W-1:0] new_dist,
   input  logic [HANDLE_BITS-1:0]      prev_handle,
   input  logic [nksil_pkg::DIST_W-1:0] prev_dist,
   output nksil_pkg::cell_stat_type    stat,
   output logic [HANDLE_BITS-1:0]      handle,
   output logic [nksil_pkg::DIST_W-1:0] entry_dist
);
   import nksil_pkg::*;

   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [DIST_W-1:0]      dist_ff, dist_in;

   always_comb begin
      stat.le       = ctl.occupied && (dist_ff <= new_dist);
      stat.take_new = !stat.le && ctl.prev_le;
      handle_in     = handle_ff;
      dist_in       = dist_ff;
      if (ctl.enable && !stat.le) begin
         if (ctl.prev_le) begin
            handle_in = new_handle;
            dist_in   = new_dist;
         end else begin
            handle_in = prev_handle;
            dist_in   = prev_dist;
         end
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      dist_ff   <= dist_in;
   end

   assign handle     = handle_ff;
   assign entry_dist = dist_ff;

endmodule

// File: rtl/nearest_k_sorted_insert_list_unit.sv
// ----------------------------------------------------------------------------
// nearest_k_sorted_insert_list_unit
// Keeps the nearest max_lights (<= depth) entries sorted by squared distance.
// ----------------------------------------------------------------------------
// A request without end_list is taken in one cycle: every cell of the row
// compares its distance with the offer at once and keeps, loads or shifts in
// the same clock, so start may be held high every cycle. A request with
// end_list starts a readout, with busy high and no request taken: one result
// per entry after the insert (an empty result if none), one per cycle, is
// shown on rsp_* with rsp_strobe, rank 0 first. The receiver cannot stall a
// result. The max_lights register (csr_we, csr_wdata) may be written only
// while busy is low.
module nearest_k_sorted_insert_list_unit #(
   parameter int LIST_DEPTH  = 8,
   parameter int HANDLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [nksil_pkg::ID_W-1:0]   req_light_id,
   input  logic [nksil_pkg::DIST_W-1:0] req_dist_sqr,
   input  logic                         req_start_list,
   input  logic                         req_end_list,
   output logic                         rsp_strobe,
   output logic [nksil_pkg::RANK_W-1:0] rsp_rank,
   output logic [nksil_pkg::ID_W-1:0]   rsp_out_light_id,
   output logic [nksil_pkg::DIST_W-1:0] rsp_out_dist_sqr,
   output logic                         rsp_entry_valid,
   output logic                         rsp_last_entry,
   input  logic                         csr_we,
   input  logic [nksil_pkg::CSR_W-1:0]  csr_wdata
);
   import nksil_pkg::*;

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CAP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   state_type         state_ff, state_in;
   logic [CSR_W-1:0]  max_lights_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;

   logic              accept;
   logic [CAP_W-1:0]  wide_max;
   logic [CNT_W-1:0]  cap;
   logic [CNT_W-1:0]  eff_count;
   logic [HANDLE_BITS-1:0] new_handle;
   logic              inserted;
   logic              rd_last;

   logic [HANDLE_BITS-1:0] cell_handle [LIST_DEPTH];
   logic [DIST_W-1:0]      cell_dist   [LIST_DEPTH];
   cell_stat_type          cell_stat   [LIST_DEPTH];
   cell_ctl_type           cell_ctl    [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]  ins_vec;

   assign accept     = start && !busy;
   assign new_handle = HANDLE_BITS'(req_light_id);
   assign wide_max   = CAP_W'(max_lights_ff);
   assign cap        = CNT_W'((wide_max > CAP_W'(LIST_DEPTH)) ? CAP_W'(LIST_DEPTH) : wide_max);

   always_comb begin
      if (req_start_list) begin
         eff_count = '0;
      end else if (count_ff > cap) begin
         eff_count = cap;
      end else begin
         eff_count = count_ff;
      end
   end

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic [HANDLE_BITS-1:0] prev_handle;
      logic [DIST_W-1:0]      prev_dist;

      if (i == 0) begin : g_head
         assign cell_ctl[i].prev_le = 1'b1;
         assign prev_handle         = new_handle;
         assign prev_dist           = req_dist_sqr;
      end else begin : g_body
         assign cell_ctl[i].prev_le = cell_stat[i-1].le;
         assign prev_handle         = cell_handle[i-1];
         assign prev_dist           = cell_dist[i-1];
      end

      assign cell_ctl[i].enable   = accept;
      assign cell_ctl[i].occupied = CNT_W'(i) < eff_count;
      assign ins_vec[i]           = cell_stat[i].take_new && (CNT_W'(i) < cap);

      nksil_cell #(
         .HANDLE_BITS (HANDLE_BITS)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .new_handle  (new_handle),
         .new_dist    (req_dist_sqr),
         .prev_handle (prev_handle),
         .prev_dist   (prev_dist),
         .stat        (cell_stat[i]),
         .handle      (cell_handle[i]),
         .entry_dist  (cell_dist[i])
      );
   end

   assign inserted = |ins_vec;
   assign rd_last  = (count_ff == '0) || ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      busy      = 1'b0;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in  = (inserted && (eff_count < cap)) ? eff_count + CNT_W'(1) : eff_count;
               rd_idx_in = '0;
               if (req_end_list) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            busy       = 1'b1;
            rsp_strobe = 1'b1;
            rd_idx_in  = rd_idx_ff + IDX_W'(1);
            if (rd_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         max_lights_ff <= MAX_LIGHTS_RESET;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         if (csr_we) begin
            max_lights_ff <= csr_wdata;
         end
      end
   end

   assign rsp_entry_valid  = (count_ff != '0);
   assign rsp_last_entry   = rd_last;
   assign rsp_rank         = rsp_entry_valid ? RANK_W'(rd_idx_ff) : '0;
   assign rsp_out_light_id = rsp_entry_valid ? ID_W'(cell_handle[rd_idx_ff]) : '0;
   assign rsp_out_dist_sqr = rsp_entry_valid ? cell_dist[rd_idx_ff] : '0;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count beyond list depth");

   a_readout_follows: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_list |=> rsp_strobe && rsp_rank == '0)
      else $error("readout did not start at rank 0");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_entry_valid |-> rsp_last_entry)
      else $error("empty result not marked last");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_entry |=> !busy)
      else $error("busy held after last result");

   a_rank_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_entry |=>
         rsp_strobe && rsp_rank == RANK_W'($past(rsp_rank) + RANK_W'(1)))
      else $error("readout rank did not advance");
`endif

endmodule

// File: test/nearest_k_sorted_insert_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_k_sorted_insert_list_checker
// Tracks accepted requests and register writes, keeps its own copy of the
// sorted list, queues the readout each end_list request should produce and
// compares every strobed result against the oldest queued entry.
// ----------------------------------------------------------------------------
module nearest_k_sorted_insert_list_checker #(
   parameter int LIST_DEPTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [nksil_pkg::ID_W-1:0]   req_light_id,
   input  logic [nksil_pkg::DIST_W-1:0] req_dist_sqr,
   input  logic                         req_start_list,
   input  logic                         req_end_list,
   input  logic                         rsp_strobe,
   input  logic [nksil_pkg::RANK_W-1:0] rsp_rank,
   input  logic [nksil_pkg::ID_W-1:0]   rsp_out_light_id,
   input  logic [nksil_pkg::DIST_W-1:0] rsp_out_dist_sqr,
   input  logic                         rsp_entry_valid,
   input  logic                         rsp_last_entry,
   input  logic                         csr_we,
   input  logic [nksil_pkg::CSR_W-1:0]  csr_wdata,
   output int                           mismatch_count,
   output int                           results_pending
);
   import nksil_pkg::*;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [ID_W-1:0]   light_id;
      logic [DIST_W-1:0] dist_sqr;
      logic              entry_valid;
      logic              last_entry;
   } readout_entry_type;

   logic [ID_W-1:0]   list_id   [LIST_DEPTH];
   logic [DIST_W-1:0] list_dist [LIST_DEPTH];
   int unsigned       list_count;
   logic [CSR_W-1:0]  max_lights;
   readout_entry_type expected_readout [$];

   task automatic insert_offer(input logic [ID_W-1:0] id, input logic [DIST_W-1:0] offer_dist,
                               input logic clear_first, input logic read_out);
      int unsigned cap;
      int unsigned pos;
      int unsigned last;
      int unsigned k;
      readout_entry_type entry;
      cap = (max_lights > LIST_DEPTH) ? LIST_DEPTH : max_lights;
      if (list_count > cap) list_count = cap;
      if (clear_first) list_count = 0;
      pos = 0;
      while (pos < list_count && list_dist[pos] <= offer_dist) pos++;
      if (pos < cap) begin
         last = (list_count < cap) ? list_count : cap - 1;
         for (k = last; k > pos; k--) begin
            list_id[k]   = list_id[k-1];
            list_dist[k] = list_dist[k-1];
         end
         list_id[pos]   = id;
         list_dist[pos] = offer_dist;
         if (list_count < cap) list_count++;
      end
      if (read_out) begin
         if (list_count == 0) begin
            entry = '0;
            entry.last_entry = 1'b1;
            expected_readout.push_back(entry);
         end else begin
            for (k = 0; k < list_count; k++) begin
               entry.rank        = k[RANK_W-1:0];
               entry.light_id    = list_id[k];
               entry.dist_sqr    = list_dist[k];
               entry.entry_valid = 1'b1;
               entry.last_entry  = (k + 1 == list_count);
               expected_readout.push_back(entry);
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      readout_entry_type want;
      if (reset) begin
         list_count = 0;
         max_lights = MAX_LIGHTS_RESET;
         expected_readout.delete();
      end else begin
         if (start && !busy)
            insert_offer(req_light_id, req_dist_sqr, req_start_list, req_end_list);
         if (csr_we) max_lights = csr_wdata;
         if (rsp_strobe) begin
            if (expected_readout.size() == 0) begin
               $display("%0t: unexpected result, expected none, got rank %0d id %0h",
                        $time, rsp_rank, rsp_out_light_id);
               mismatch_count++;
            end else begin
               want = expected_readout.pop_front();
               check_field("rank", 32'(want.rank), 32'(rsp_rank));
               check_field("out_light_id", 32'(want.light_id), 32'(rsp_out_light_id));
               check_field("out_dist_sqr", want.dist_sqr, rsp_out_dist_sqr);
               check_field("entry_valid", 32'(want.entry_valid), 32'(rsp_entry_valid));
               check_field("last_entry", 32'(want.last_entry), 32'(rsp_last_entry));
            end
         end
      end
      results_pending = expected_readout.size();
   end

endmodule

// File: test/nearest_k_sorted_insert_list_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_k_sorted_insert_list_unit_tb
// Drives directed and random candidate lists into the sorted insertion list,
// changes the capacity register between phases, and lets the checker compare
// every readout. Random requests come in bursts with random gaps.
// ----------------------------------------------------------------------------
module nearest_k_sorted_insert_list_unit_tb;
   import nksil_pkg::*;

   localparam int RANDOM_REQUESTS = 400;
   localparam int CYCLE_LIMIT     = 200000;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [ID_W-1:0]   req_light_id;
   logic [DIST_W-1:0] req_dist_sqr;
   logic              req_start_list;
   logic              req_end_list;
   logic              rsp_strobe;
   logic [RANK_W-1:0] rsp_rank;
   logic [ID_W-1:0]   rsp_out_light_id;
   logic [DIST_W-1:0] rsp_out_dist_sqr;
   logic              rsp_entry_valid;
   logic              rsp_last_entry;
   logic              csr_we;
   logic [CSR_W-1:0]  csr_wdata;
   int                mismatch_count;
   int                results_pending;
   int                cycle_count = 0;
   int                burst_left = 0;

   nearest_k_sorted_insert_list_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_light_id     (req_light_id),
      .req_dist_sqr     (req_dist_sqr),
      .req_start_list   (req_start_list),
      .req_end_list     (req_end_list),
      .rsp_strobe       (rsp_strobe),
      .rsp_rank         (rsp_rank),
      .rsp_out_light_id (rsp_out_light_id),
      .rsp_out_dist_sqr (rsp_out_dist_sqr),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_last_entry   (rsp_last_entry),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   nearest_k_sorted_insert_list_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_light_id     (req_light_id),
      .req_dist_sqr     (req_dist_sqr),
      .req_start_list   (req_start_list),
      .req_end_list     (req_end_list),
      .rsp_strobe       (rsp_strobe),
      .rsp_rank         (rsp_rank),
      .rsp_out_light_id (rsp_out_light_id),
      .rsp_out_dist_sqr (rsp_out_dist_sqr),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_last_entry   (rsp_last_entry),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .results_pending  (results_pending)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // all tasks are entered and left just after a rising edge
   task automatic send_request(input logic [ID_W-1:0] id, input logic [DIST_W-1:0] offer_dist,
                               input logic clear_first, input logic read_out);
      @(negedge clock);
      start          <= 1'b1;
      req_light_id   <= id;
      req_dist_sqr   <= offer_dist;
      req_start_list <= clear_first;
      req_end_list   <= read_out;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_readouts();
      @(negedge clock);
      start <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_max_lights(input logic [CSR_W-1:0] value);
      @(negedge clock);
      start     <= 1'b0;
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic pace_sender();
      if (burst_left == 0) begin
         idle($urandom_range(1, 6));
         burst_left = $urandom_range(1, 24);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [DIST_W-1:0] pick_distance();
      case ($urandom_range(0, 3))
         0: pick_distance = $urandom_range(0, 15);
         1: pick_distance = $urandom;
         2: pick_distance = $urandom_range(0, 1) ? '1 : '0;
         default: pick_distance = $urandom_range(0, 1000);
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      case ($urandom_range(0, 7))
         0: pick_id = '0;
         1: pick_id = '1;
         default: pick_id = ID_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_capacity();
      case ($urandom_range(0, 5))
         0: pick_capacity = 4'd0;
         1: pick_capacity = 4'd15;
         2: pick_capacity = 4'd8;
         3: pick_capacity = 4'd1;
         default: pick_capacity = CSR_W'($urandom_range(0, 15));
      endcase
   endfunction

   initial begin
      int sent;
      int list_len;
      int lists;
      logic clear_first;
      logic read_out;
      reset          = 1'b1;
      start          = 1'b0;
      req_light_id   = '0;
      req_dist_sqr   = '0;
      req_start_list = 1'b0;
      req_end_list   = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full list of 8: ties, extremes, overflow and a dropped far offer
      send_request(16'h0001, 32'd100, 1'b1, 1'b0);
      send_request(16'h0002, 32'd50, 1'b0, 1'b0);
      send_request(16'h0003, 32'd100, 1'b0, 1'b0);
      send_request(16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_request(16'h0000, 32'd0, 1'b0, 1'b0);
      send_request(16'h0004, 32'd75, 1'b0, 1'b0);
      send_request(16'h0005, 32'd100, 1'b0, 1'b0);
      send_request(16'h0006, 32'd20, 1'b0, 1'b0);
      send_request(16'h1234, 32'd60, 1'b0, 1'b0);
      send_request(16'h4321, 32'hFFFF_FFFF, 1'b0, 1'b1);
      drain_readouts();

      // capacity lowered below the stored count
      write_max_lights(4'd3);
      send_request(16'h00AA, 32'd10, 1'b0, 1'b1);
      drain_readouts();

      // zero capacity gives the empty readout
      write_max_lights(4'd0);
      send_request(16'h5555, 32'd5, 1'b1, 1'b1);
      drain_readouts();

      // capacity above depth saturates
      write_max_lights(4'd15);
      for (int i = 0; i < 10; i++)
         send_request(ID_W'(32'hA000 + i), 32'hFFFF_FFF0 - DIST_W'(7 * i), i == 0, i == 9);
      drain_readouts();

      write_max_lights(4'd1);
      send_request(16'hAAAA, 32'h8000_0000, 1'b1, 1'b0);
      send_request(16'h5555, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send_request(16'h0F0F, 32'h7FFF_FFFF, 1'b0, 1'b1);
      drain_readouts();
      write_max_lights(4'd8);

      sent  = 0;
      lists = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (lists % 6 == 5) begin
            drain_readouts();
            write_max_lights(pick_capacity());
         end
         lists++;
         list_len = $urandom_range(1, 12);
         for (int i = 0; i < list_len; i++) begin
            clear_first = (i == 0) && ($urandom_range(0, 9) != 0);
            read_out    = (i == list_len - 1);
            if ($urandom_range(0, 7) == 0) begin
               clear_first = 1'($urandom_range(0, 1));
               read_out    = 1'($urandom_range(0, 1));
            end
            pace_sender();
            send_request(pick_id(), pick_distance(), clear_first, read_out);
            sent++;
         end
      end

      drain_readouts();
      idle(10);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/nksil_pkg.sv
rtl/nksil_cell.sv
rtl/nearest_k_sorted_insert_list_unit.sv
test/nearest_k_sorted_insert_list_checker.sv
test/nearest_k_sorted_insert_list_unit_tb.sv
